>>> rtl/pwl_pkg.sv
`default_nettype none

package pwl_pkg;

   localparam int DEFAULT_MAX_POINTS = 32;
   localparam int DATA_W             = 32;
   localparam int COUNT_W            = 6;
   localparam int INDEX_W            = 5;
   localparam int FRAC_W             = 16;
   // quotient t lies in 0 .. 2**FRAC_W
   localparam int T_W                = FRAC_W + 1;

   localparam logic [DATA_W-1:0]  ONE_Q16       = 32'h0001_0000;
   localparam logic [COUNT_W-1:0] COUNT_RESET   = 6'd2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] axis;
      logic signed [DATA_W-1:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_SUM
   } state_type;

endpackage

`default_nettype wire

>>> rtl/piecewise_linear_lookup.sv
`default_nettype none

// Piecewise linear lookup over a table of (axis, value) breakpoints, Q16.16.
// Requests enter on start/busy: a request is taken at a clock edge with start
// high and busy low. req_func selects a breakpoint write (req_point_index,
// req_point_axis, req_point_value) or an evaluate (req_query_x).
// A write completes at the accepting edge and gives no result; busy stays low.
// An evaluate raises busy until its result is registered. The result shows on
// rsp_value_y for one cycle with rsp_valid high; the receiver cannot stall.
// An evaluate reads entry zero and answers with its value for a query at or
// below the first axis point, else reads the last used entry and answers with
// its value for a query at or above it, else scans the table from entry one,
// one entry per cycle through the single read port of the breakpoint memory.
// Segment k (entries k, k+1) that encloses the query gives its left value when
// its span is zero or negative, and else interpolates through the 17-step
// restoring divider.
// csr_point_count (point_count) may be written only while idle.
// Reset (synchronous) restores point_count = 2 and a table mapping 0.0 to 0.0
// and 1.0 to 1.0 at once, through per-entry valid bits; no clearing pass.
module piecewise_linear_lookup
   import pwl_pkg::*;
#(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic                     req_func,
   input  wire logic [INDEX_W-1:0]       req_point_index,
   input  wire logic signed [DATA_W-1:0] req_point_axis,
   input  wire logic signed [DATA_W-1:0] req_point_value,
   input  wire logic signed [DATA_W-1:0] req_query_x,
   output      logic                     rsp_valid,
   output      logic signed [DATA_W-1:0] rsp_value_y,
   input  wire logic                     csr_write_en,
   input  wire logic [COUNT_W-1:0]       csr_point_count
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   // wide enough for point_count and for MAX_POINTS itself
   localparam int N_W   = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
   localparam int SUB_W = DATA_W + 1;          // differences of two Q16.16 values
   localparam int REM_W = SUB_W + 1;           // partial remainder, below 2*span
   localparam int PROD_W = T_W + 1 + SUB_W;    // signed t times signed dv

   // ---------------------------------------------------------------------
   // Breakpoint memory: one write port, one registered read port.
   // Valid bits mark written entries; an unwritten entry reads as its
   // reset value (1.0/1.0 for entry one, zero elsewhere).
   // ---------------------------------------------------------------------
   entry_type             mem [MAX_POINTS];
   logic [MAX_POINTS-1:0] valid_ff;
   entry_type             rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rd_one_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic                  mem_we;
   entry_type             ent;

   assign wr_addr = IDX_W'(req_point_index);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= '{axis: req_point_axis, value: req_point_value};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         rd_one_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
         rd_one_ff   <= (rd_addr == IDX_W'(1));
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         ent = rd_data_ff;
      end else if (rd_one_ff) begin
         ent = '{axis: ONE_Q16, value: ONE_Q16};
      end else begin
         ent = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Configuration: point count, clamped to 1 .. MAX_POINTS when used.
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0] point_count_ff;
   logic [N_W-1:0]     count_ext;
   logic [N_W-1:0]     n_used;
   logic [IDX_W-1:0]   last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= COUNT_RESET;
      end else if (csr_write_en) begin
         point_count_ff <= csr_point_count;
      end
   end

   always_comb begin
      count_ext = N_W'(point_count_ff);
      if (count_ext == '0) begin
         n_used = N_W'(1);
      end else if (count_ext > N_W'(MAX_POINTS)) begin
         n_used = N_W'(MAX_POINTS);
      end else begin
         n_used = count_ext;
      end
      last_idx = IDX_W'(n_used - N_W'(1));
   end

   // ---------------------------------------------------------------------
   // Evaluate sequencer
   // ---------------------------------------------------------------------
   state_type                state_ff, state_in;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [DATA_W-1:0] left_a_ff, left_a_in;
   logic signed [DATA_W-1:0] left_v_ff, left_v_in;
   logic signed [DATA_W-1:0] right_v_ff, right_v_in;
   logic signed [DATA_W-1:0] first_v_ff, first_v_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [SUB_W-1:0]         span_ff, span_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [T_W-1:0]           quo_ff, quo_in;
   logic [4:0]               step_ff, step_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;

   logic signed [SUB_W-1:0]  span_s;
   logic signed [SUB_W-1:0]  dist_s;
   logic signed [SUB_W-1:0]  dv_s;
   logic                     in_seg;
   logic                     div_ge;
   logic [REM_W-1:0]         div_rem;
   logic                     accept;

   assign accept = start && (state_ff == ST_IDLE);

   // segment arithmetic on the left point (registered) and the entry read now
   assign span_s = SUB_W'(ent.axis) - SUB_W'(left_a_ff);
   assign dist_s = SUB_W'(x_ff) - SUB_W'(left_a_ff);
   assign in_seg = (x_ff >= left_a_ff) && (x_ff <= ent.axis);
   assign dv_s   = SUB_W'(right_v_ff) - SUB_W'(left_v_ff);

   // one restoring division step
   assign div_ge  = (rem_ff >= REM_W'(span_ff));
   assign div_rem = div_ge ? (rem_ff - REM_W'(span_ff)) : rem_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      left_a_in    = left_a_ff;
      left_v_in    = left_v_ff;
      right_v_in   = right_v_ff;
      first_v_in   = first_v_ff;
      scan_idx_in  = scan_idx_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rd_addr      = '0;
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_EVAL) begin
                  // read entry zero first
                  x_in     = req_query_x;
                  rd_addr  = '0;
                  state_in = ST_FIRST;
               end else begin
                  // drop writes beyond the table
                  mem_we = (32'(req_point_index) < 32'(MAX_POINTS));
               end
            end
         end

         ST_FIRST: begin
            left_a_in  = ent.axis;
            left_v_in  = ent.value;
            first_v_in = ent.value;
            if (x_ff <= ent.axis) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = ent.value;
               state_in     = ST_IDLE;
            end else begin
               rd_addr  = last_idx;
               state_in = ST_LAST;
            end
         end

         ST_LAST: begin
            if (x_ff >= ent.axis) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = ent.value;
               state_in     = ST_IDLE;
            end else begin
               // here at least two points are in use; start the scan at entry one
               rd_addr     = IDX_W'(1);
               scan_idx_in = IDX_W'(1);
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (in_seg) begin
               if (span_s[SUB_W-1] || (span_s == '0)) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = left_v_ff;
                  state_in     = ST_IDLE;
               end else begin
                  right_v_in = ent.value;
                  span_in    = span_s;
                  rem_in     = REM_W'(dist_s);
                  quo_in     = '0;
                  step_in    = '0;
                  state_in   = ST_DIV;
               end
            end else if ((N_W'(scan_idx_ff) + N_W'(1)) < n_used) begin
               // advance: current entry becomes the left point
               left_a_in   = ent.axis;
               left_v_in   = ent.value;
               rd_addr     = scan_idx_ff + IDX_W'(1);
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end else begin
               // no segment encloses x
               rsp_valid_in = 1'b1;
               rsp_value_in = first_v_ff;
               state_in     = ST_IDLE;
            end
         end

         ST_DIV: begin
            // remainder stays below span, so the shift never loses a bit
            quo_in  = {quo_ff[T_W-2:0], div_ge};
            rem_in  = {div_rem[REM_W-2:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(T_W - 1)) begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            // widen both operands so the product keeps every bit
            prod_in  = PROD_W'($signed({1'b0, quo_ff})) * PROD_W'(dv_s);
            state_in = ST_SUM;
         end

         ST_SUM: begin
            // arithmetic shift floors toward minus infinity
            rsp_valid_in = 1'b1;
            rsp_value_in = left_v_ff + prod_ff[FRAC_W +: DATA_W];
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers: no reset needed
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      left_a_ff    <= left_a_in;
      left_v_ff    <= left_v_in;
      right_v_ff   <= right_v_in;
      first_v_ff   <= first_v_in;
      scan_idx_ff  <= scan_idx_in;
      span_ff      <= span_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value_y = rsp_value_ff;

endmodule

`default_nettype wire
